[hw/rtl/pcs_pkg.sv]
// Package for the PLL configuration sequencer.
// Holds action, status and register index codes and the controller/datapath bundles.
// No dependencies.
package pcs_pkg;

  localparam logic CMD_CONFIGURE   = 1'b0;
  localparam logic CMD_LOCK_SAMPLE = 1'b1;

  localparam logic [3:0] ACT_XTAL_ON    = 4'd0;
  localparam logic [3:0] ACT_SEL_XTAL   = 4'd1;
  localparam logic [3:0] ACT_BYPASS     = 4'd2;
  localparam logic [3:0] ACT_CLEAR_DIV  = 4'd3;
  localparam logic [3:0] ACT_PLL_OFF    = 4'd4;
  localparam logic [3:0] ACT_WRITE_MULT = 4'd5;
  localparam logic [3:0] ACT_SET_DIV    = 4'd6;
  localparam logic [3:0] ACT_ENABLE_CLK = 4'd7;
  localparam logic [3:0] ACT_DONE       = 4'd8;
  localparam logic [3:0] ACT_ERROR      = 4'd9;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_COMBO = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;

  localparam logic [1:0] CFG_SOURCE_SELECT   = 2'd0;
  localparam logic [1:0] CFG_CRYSTAL_FREQ    = 2'd1;
  localparam logic [1:0] CFG_LOCK_POLL_LIMIT = 2'd2;

  localparam logic [31:0] INT_OSC_HZ      = 32'd10000000;
  localparam logic [31:0] POLL_LIMIT_RST  = 32'd1000;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       take_hit;
    logic       poll_dec;
    logic       poll_reload;
    logic       lock_inc;
    logic       emit;
    logic [3:0] act;
    logic [1:0] st;
    logic       last;
  } pcs_cmd_t;

  typedef struct packed {
    logic src_xtal;
    logic hit;
    logic search_end;
    logic out_free;
    logic polls_zero;
    logic polls_one;
    logic locks_final;
  } pcs_sts_t;

endpackage

[hw/rtl/pcs_ctrl.sv]
// Controller state machine of the PLL configuration sequencer.
// Sequences search and result emission; depends on pcs_pkg.
module pcs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic             lock_seen_i,
  input  pcs_pkg::pcs_sts_t sts_i,
  output pcs_pkg::pcs_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_XON  = 4'd1;
  localparam logic [3:0] S_XSEL = 4'd2;
  localparam logic [3:0] S_SRCH = 4'd3;
  localparam logic [3:0] S_BYP  = 4'd4;
  localparam logic [3:0] S_CLR  = 4'd5;
  localparam logic [3:0] S_OFF  = 4'd6;
  localparam logic [3:0] S_WMUL = 4'd7;
  localparam logic [3:0] S_SDIV = 4'd8;
  localparam logic [3:0] S_ENCK = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;
  localparam logic [3:0] S_ERRN = 4'd11;
  localparam logic [3:0] S_ERRT = 4'd12;

  logic [3:0] state_q, state_d;
  logic       locking_q, locking_d;
  logic       accept;
  logic [3:0] emit_next;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    locking_d = locking_q;
    cmd_o     = '0;
    cmd_o.act = pcs_pkg::ACT_XTAL_ON;
    cmd_o.st  = pcs_pkg::ST_OK;
    emit_next = S_IDLE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i == pcs_pkg::CMD_CONFIGURE) begin
            cmd_o.load = 1'b1;
            locking_d  = 1'b0;
            state_d    = sts_i.src_xtal ? S_XON : S_SRCH;
          end else if (locking_q) begin
            if (sts_i.polls_zero) begin
              locking_d = 1'b0;
              state_d   = S_ERRT;
            end else if (!lock_seen_i) begin
              cmd_o.poll_dec = 1'b1;
              if (sts_i.polls_one) begin
                locking_d = 1'b0;
                state_d   = S_ERRT;
              end
            end else begin
              cmd_o.lock_inc = 1'b1;
              if (sts_i.locks_final) begin
                locking_d = 1'b0;
                state_d   = S_SDIV;
              end else begin
                cmd_o.poll_reload = 1'b1;
                state_d           = S_OFF;
              end
            end
          end
        end
      end
      S_SRCH: begin
        if (sts_i.hit) begin
          cmd_o.take_hit = 1'b1;
          locking_d      = 1'b1;
          state_d        = S_BYP;
        end else if (sts_i.search_end) begin
          state_d = S_ERRN;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        case (state_q)
          S_XON: begin
            cmd_o.act = pcs_pkg::ACT_XTAL_ON;
            emit_next = S_XSEL;
          end
          S_XSEL: begin
            cmd_o.act = pcs_pkg::ACT_SEL_XTAL;
            emit_next = S_SRCH;
          end
          S_BYP: begin
            cmd_o.act = pcs_pkg::ACT_BYPASS;
            emit_next = S_CLR;
          end
          S_CLR: begin
            cmd_o.act = pcs_pkg::ACT_CLEAR_DIV;
            emit_next = S_OFF;
          end
          S_OFF: begin
            cmd_o.act = pcs_pkg::ACT_PLL_OFF;
            emit_next = S_WMUL;
          end
          S_WMUL: begin
            cmd_o.act  = pcs_pkg::ACT_WRITE_MULT;
            cmd_o.last = 1'b1;
          end
          S_SDIV: begin
            cmd_o.act = pcs_pkg::ACT_SET_DIV;
            emit_next = S_ENCK;
          end
          S_ENCK: begin
            cmd_o.act = pcs_pkg::ACT_ENABLE_CLK;
            emit_next = S_DONE;
          end
          S_DONE: begin
            cmd_o.act  = pcs_pkg::ACT_DONE;
            cmd_o.last = 1'b1;
          end
          S_ERRN: begin
            cmd_o.act  = pcs_pkg::ACT_ERROR;
            cmd_o.st   = pcs_pkg::ST_NO_COMBO;
            cmd_o.last = 1'b1;
          end
          S_ERRT: begin
            cmd_o.act  = pcs_pkg::ACT_ERROR;
            cmd_o.st   = pcs_pkg::ST_TIMEOUT;
            cmd_o.last = 1'b1;
          end
          default: begin
            emit_next = S_IDLE;
          end
        endcase
        if (sts_i.out_free) begin
          cmd_o.emit = (state_q <= S_ERRT);
          state_d    = emit_next;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      locking_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      locking_q <= locking_d;
    end
  end

endmodule

[hw/rtl/pcs_dpath.sv]
// Datapath of the PLL configuration sequencer.
// Holds configuration, divider/multiplier search, lock counters and the result register;
// depends on pcs_pkg.
module pcs_dpath #(
  parameter int LOCK_REPEATS = 5,
  parameter int MULT_MAX     = 127,
  parameter int DIV_MAX      = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic [31:0]       target_freq_i,
  input  pcs_pkg::pcs_cmd_t cmd_i,
  output pcs_pkg::pcs_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        action_o,
  output logic [9:0]        reg_value_o,
  output logic [1:0]        status_o,
  output logic [31:0]       sys_freq_o,
  output logic [29:0]       low_speed_freq_o,
  output logic [30:0]       pwm_freq_o,
  output logic              last_o
);

  logic        src_sel_q;
  logic [31:0] xtal_q;
  logic [31:0] limit_q;

  logic [31:0] src_q, tgt_q, cpu_q, polls_q;
  logic [6:0]  m_q, mult_q;
  logic [5:0]  d_q, div_q;
  logic [38:0] p_q;
  logic [37:0] td_q;
  logic [2:0]  locks_q;
  logic [39:0] diff;
  logic [31:0] src_d;

  logic        ov_q, last_q;
  logic [3:0]  act_q;
  logic [9:0]  reg_q;
  logic [1:0]  st_q;
  logic [31:0] sys_q;

  assign src_d = src_sel_q ? xtal_q : pcs_pkg::INT_OSC_HZ;
  assign diff  = {1'b0, p_q} - {2'b0, td_q};

  assign sts_o.src_xtal    = src_sel_q;
  assign sts_o.hit         = !diff[39] && (diff[38:0] < {33'b0, d_q});
  assign sts_o.search_end  = (m_q == 7'(MULT_MAX)) && (d_q == 6'(DIV_MAX));
  assign sts_o.out_free    = !ov_q || !out_stall_i;
  assign sts_o.polls_zero  = (polls_q == 32'd0);
  assign sts_o.polls_one   = (polls_q == 32'd1);
  assign sts_o.locks_final = (({1'b0, locks_q} + 4'd1) >= 4'(LOCK_REPEATS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_sel_q <= 1'b0;
      xtal_q    <= 32'd0;
      limit_q   <= pcs_pkg::POLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcs_pkg::CFG_SOURCE_SELECT:   src_sel_q <= cfg_wdata_i[0];
        pcs_pkg::CFG_CRYSTAL_FREQ:    xtal_q    <= cfg_wdata_i;
        pcs_pkg::CFG_LOCK_POLL_LIMIT: limit_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      src_q <= src_d;
      tgt_q <= target_freq_i;
      m_q   <= 7'd1;
      d_q   <= 6'd2;
      p_q   <= {7'b0, src_d};
      td_q  <= {5'b0, target_freq_i, 1'b0};
    end else if (cmd_i.step) begin
      if (m_q == 7'(MULT_MAX)) begin
        m_q  <= 7'd1;
        d_q  <= d_q + 6'd1;
        p_q  <= {7'b0, src_q};
        td_q <= td_q + {6'b0, tgt_q};
      end else begin
        m_q <= m_q + 7'd1;
        p_q <= p_q + {7'b0, src_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_q   <= 32'd0;
      mult_q  <= 7'd0;
      div_q   <= 6'd0;
      polls_q <= 32'd0;
      locks_q <= 3'd0;
    end else begin
      if (cmd_i.take_hit) begin
        cpu_q   <= tgt_q;
        mult_q  <= m_q;
        div_q   <= d_q;
        polls_q <= limit_q;
        locks_q <= 3'd0;
      end else begin
        if (cmd_i.poll_dec) begin
          polls_q <= polls_q - 32'd1;
        end else if (cmd_i.poll_reload) begin
          polls_q <= limit_q;
        end
        if (cmd_i.lock_inc) begin
          locks_q <= locks_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      act_q  <= cmd_i.act;
      st_q   <= cmd_i.st;
      last_q <= cmd_i.last;
      case (cmd_i.act)
        pcs_pkg::ACT_WRITE_MULT: reg_q <= {3'b0, mult_q};
        pcs_pkg::ACT_SET_DIV:    reg_q <= {4'b0, div_q - 6'd1};
        default:                 reg_q <= 10'd0;
      endcase
      sys_q <= (cmd_i.act == pcs_pkg::ACT_DONE) ? cpu_q : 32'd0;
    end
  end

  assign out_valid_o      = ov_q;
  assign action_o         = act_q;
  assign reg_value_o      = reg_q;
  assign status_o         = st_q;
  assign sys_freq_o       = sys_q;
  assign low_speed_freq_o = sys_q[31:2];
  assign pwm_freq_o       = sys_q[31:1];
  assign last_o           = last_q;

endmodule

[hw/rtl/pll_config_sequencer_unit.sv]
// PLL configuration sequencer top level; instantiates pcs_ctrl and pcs_dpath, uses pcs_pkg.
// Configure request: decode, crystal actions if the crystal is selected, then the search tests one
// divider/multiplier pair per cycle (divider 2..DIV_MAX, multiplier 1..MULT_MAX), then the results.
// Lock sample: decode, then its results; an unlocked sample emits a result only on poll timeout.
// One request at a time; results wait in a single output register under stall.
// Reset: idle, not locking, configuration at reset values, no result pending.
module pll_config_sequencer_unit #(
  parameter int LOCK_REPEATS = 5,
  parameter int MULT_MAX     = 127,
  parameter int DIV_MAX      = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [31:0] target_freq_i,
  input  logic        lock_seen_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  action_o,
  output logic [9:0]  reg_value_o,
  output logic [1:0]  status_o,
  output logic [31:0] sys_freq_o,
  output logic [29:0] low_speed_freq_o,
  output logic [30:0] pwm_freq_o,
  output logic        last_o
);

  pcs_pkg::pcs_cmd_t ctl_cmd;
  pcs_pkg::pcs_sts_t dp_sts;

  pcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .lock_seen_i (lock_seen_i),
    .sts_i       (dp_sts),
    .cmd_o       (ctl_cmd)
  );

  pcs_dpath #(
    .LOCK_REPEATS (LOCK_REPEATS),
    .MULT_MAX     (MULT_MAX),
    .DIV_MAX      (DIV_MAX)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .target_freq_i    (target_freq_i),
    .cmd_i            (ctl_cmd),
    .sts_o            (dp_sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .reg_value_o      (reg_value_o),
    .status_o         (status_o),
    .sys_freq_o       (sys_freq_o),
    .low_speed_freq_o (low_speed_freq_o),
    .pwm_freq_o       (pwm_freq_o),
    .last_o           (last_o)
  );

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == pcs_pkg::CMD_CONFIGURE) |=> in_stall_o)
    else $error("configure request did not start a sequence");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((action_o == pcs_pkg::ACT_DONE) || (action_o == pcs_pkg::ACT_ERROR))
    |-> last_o)
    else $error("done or error result not marked last");

  a_status_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != pcs_pkg::ST_OK) |-> (action_o == pcs_pkg::ACT_ERROR))
    else $error("nonzero status on a non-error result");

  a_freq_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o != pcs_pkg::ACT_DONE) |-> (sys_freq_o == 32'd0))
    else $error("frequency reported outside done result");

endmodule
